// ===== hdl/quadratic_root_solver_unit_defines.svh =====
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define QRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/qrs_pkg.sv =====
// Shared types and constants of the quadratic root solver.
package qrs_pkg;
  localparam int unsigned CoefW = 16;
  localparam int unsigned RootW = 32;
  localparam int unsigned DiscW = 35;   // b*b - 4ac, signed
  localparam int unsigned RadW  = 64;   // disc << 30, unsigned
  localparam int unsigned SqrtW = 32;
  localparam int unsigned NumW  = 34;   // -b*2^15 +- s, signed
  localparam int unsigned QuoW  = 34;   // magnitude quotient width

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_AZERO  = 2'd3
  } status_t;

  // Sideband that travels with each item through the pipeline up to the dividers.
  typedef struct packed {
    logic                     vld;
    status_t                  st;
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
  } side_t;
endpackage

// ===== hdl/qrs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [qrs_pkg::RadW-1:0]   rad,
  input  qrs_pkg::side_t             side_in,
  output logic [qrs_pkg::SqrtW-1:0]  root,
  output qrs_pkg::side_t             side_out
);
  localparam int unsigned N = qrs_pkg::SqrtW;

  logic [qrs_pkg::RadW-1:0]  rad_r  [N+1];
  logic [N+1:0]              rem_r  [N+1];
  logic [N-1:0]              res_r  [N+1];
  qrs_pkg::side_t            side_r [N+1];

  always_comb begin
    rad_r[0]  = rad;
    rem_r[0]  = '0;
    res_r[0]  = '0;
    side_r[0] = side_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    logic [qrs_pkg::RadW-1:0] rad_nxt;
    always_comb begin
      rem_sh  = {rem_r[i][N-1:0], rad_r[i][qrs_pkg::RadW-1 -: 2]};
      trial   = {res_r[i], 2'b01};
      rad_nxt = rad_r[i] << 2;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i+1].vld <= 1'b0;
      end else begin
        side_r[i+1].vld <= side_r[i].vld;
      end
      side_r[i+1].st <= side_r[i].st;
      side_r[i+1].a  <= side_r[i].a;
      side_r[i+1].b  <= side_r[i].b;
      rad_r[i+1]     <= rad_nxt;
      if (rem_sh >= trial) begin
        rem_r[i+1] <= rem_sh - trial;
        res_r[i+1] <= {res_r[i][N-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= rem_sh;
        res_r[i+1] <= {res_r[i][N-2:0], 1'b0};
      end
    end
  end

  assign root     = res_r[N];
  assign side_out = side_r[N];
endmodule

// ===== hdl/qrs_div.sv =====
// Pipelined signed restoring divider, one quotient bit per stage, saturating.
module qrs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_in,
  input  logic signed [qrs_pkg::NumW-1:0]   num,
  input  logic signed [qrs_pkg::CoefW-1:0]  den,
  output logic                              vld_out,
  output logic [qrs_pkg::RootW-1:0]         quo
);
  localparam int unsigned Q = qrs_pkg::QuoW;
  localparam int unsigned D = qrs_pkg::CoefW;

  logic [Q-1:0]   n_r   [Q+1];
  logic [D:0]     rm_r  [Q+1];
  logic [D-1:0]   d_r   [Q+1];
  logic           neg_r [Q+1];
  logic           v_r   [Q+1];

  always_comb begin
    n_r[0]   = num[qrs_pkg::NumW-1] ? Q'(-num) : Q'(num);
    d_r[0]   = den[D-1] ? D'(-den) : D'(den);
    neg_r[0] = num[qrs_pkg::NumW-1] ^ den[D-1];
    rm_r[0]  = '0;
    v_r[0]   = vld_in;
  end

  for (genvar i = 0; i < Q; i++) begin : g_stage
    logic [D+1:0] sh;
    always_comb sh = {rm_r[i], n_r[i][Q-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      d_r[i+1]   <= d_r[i];
      neg_r[i+1] <= neg_r[i];
      if (sh >= {2'b00, d_r[i]}) begin
        rm_r[i+1] <= (D+1)'(sh - {2'b00, d_r[i]});
        n_r[i+1]  <= {n_r[i][Q-2:0], 1'b1};
      end else begin
        rm_r[i+1] <= sh[D:0];
        n_r[i+1]  <= {n_r[i][Q-2:0], 1'b0};
      end
    end
  end

  // Apply sign and saturate; magnitude quotient fits Q bits.
  logic signed [Q:0] sq;
  always_comb begin
    sq = neg_r[Q] ? -$signed({1'b0, n_r[Q]}) : $signed({1'b0, n_r[Q]});
    if (sq > $signed((Q+1)'(33'sh0_7FFF_FFFF)))
      quo = 32'h7FFF_FFFF;
    else if (sq < -$signed((Q+1)'(33'sh0_8000_0000)))
      quo = 32'h8000_0000;
    else
      quo = sq[qrs_pkg::RootW-1:0];
  end
  assign vld_out = v_r[Q];
endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// Top level of the quadratic root solver.
//
//  Channel  Ports                                   Handshake
//  input    in_coef_a, in_coef_b, in_coef_c         start && !busy
//  result   out_root_plus, out_root_minus,          out_valid strobe, one cycle
//           out_status
//
// One item may start in every cycle; busy is tied low, nothing stalls.
// Pipeline: product and discriminant/radicand registers, 32 square-root
// stages (one root bit each), 1 numerator stage, 34 divider stages (one
// quotient bit each), then the output register.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so every result leaves on its strobe cycle.
`include "quadratic_root_solver_unit_defines.svh"
module quadratic_root_solver_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qrs_pkg::CoefW-1:0]  in_coef_a,
  input  logic signed [qrs_pkg::CoefW-1:0]  in_coef_b,
  input  logic signed [qrs_pkg::CoefW-1:0]  in_coef_c,
  output logic                              out_valid,
  output logic signed [qrs_pkg::RootW-1:0]  out_root_plus,
  output logic signed [qrs_pkg::RootW-1:0]  out_root_minus,
  output logic [1:0]                        out_status
);
  assign busy = 1'b0;

  // Stage 1: products.
  logic signed [31:0] bb_r, ac_r;
  qrs_pkg::side_t     s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= start;
    end
    s1_r.st <= qrs_pkg::ST_TWO;
    s1_r.a  <= in_coef_a;
    s1_r.b  <= in_coef_b;
    bb_r    <= in_coef_b * in_coef_b;
    ac_r    <= in_coef_a * in_coef_c;
  end

  // Stage 2: discriminant, status and radicand.
  logic signed [qrs_pkg::DiscW-1:0] disc;
  logic [qrs_pkg::RadW-1:0]         rad_r;
  qrs_pkg::side_t                   s2_r;
  assign disc = qrs_pkg::DiscW'(bb_r) - (qrs_pkg::DiscW'(ac_r) <<< 2);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r.vld <= s1_r.vld;
    end
    s2_r.a <= s1_r.a;
    s2_r.b <= s1_r.b;
    if (s1_r.a == '0)
      s2_r.st <= qrs_pkg::ST_AZERO;
    else if (disc < 0)
      s2_r.st <= qrs_pkg::ST_NONE;
    else if (disc == '0)
      s2_r.st <= qrs_pkg::ST_DOUBLE;
    else
      s2_r.st <= qrs_pkg::ST_TWO;
    // Hold radicand at zero for negative discriminants.
    rad_r <= disc[qrs_pkg::DiscW-1] ? '0
           : {disc[33:0], 30'b0};
  end

  // Square root stages.
  logic [qrs_pkg::SqrtW-1:0] sroot;
  qrs_pkg::side_t            s3;
  qrs_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .rad(rad_r), .side_in(s2_r),
    .root(sroot), .side_out(s3)
  );

  // Numerators.
  logic signed [qrs_pkg::NumW-1:0] np_r, nm_r, base;
  qrs_pkg::side_t                  s4_r;
  assign base = -(qrs_pkg::NumW'(s3.b) <<< 15);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld <= 1'b0;
    end else begin
      s4_r.vld <= s3.vld;
    end
    s4_r.st <= s3.st;
    s4_r.a  <= s3.a;
    s4_r.b  <= s3.b;
    np_r    <= base + $signed({2'b00, sroot});
    nm_r    <= base - $signed({2'b00, sroot});
  end

  // Divider lanes; a zero divisor is masked by status.
  logic [qrs_pkg::RootW-1:0] qp, qm;
  logic                      vp, vm;
  qrs_div u_div_p (.clk(clk), .rst_n(rst_n), .vld_in(s4_r.vld), .num(np_r),
                   .den(s4_r.a), .vld_out(vp), .quo(qp));
  qrs_div u_div_m (.clk(clk), .rst_n(rst_n), .vld_in(s4_r.vld), .num(nm_r),
                   .den(s4_r.a), .vld_out(vm), .quo(qm));

  // Status delay line matched to the divider depth.
  qrs_pkg::status_t st_d_r [qrs_pkg::QuoW+1];
  assign st_d_r[0] = s4_r.st;
  for (genvar i = 0; i < qrs_pkg::QuoW; i++) begin : g_st
    always_ff @(posedge clk) st_d_r[i+1] <= st_d_r[i];
  end

  // Output register: drop roots when no real roots or a is zero.
  logic zero_roots;
  assign zero_roots = (st_d_r[qrs_pkg::QuoW] == qrs_pkg::ST_NONE) ||
                      (st_d_r[qrs_pkg::QuoW] == qrs_pkg::ST_AZERO);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vp;
    end
    out_root_plus  <= zero_roots ? '0 : qp;
    out_root_minus <= zero_roots ? '0 : qm;
    out_status     <= st_d_r[qrs_pkg::QuoW];
  end

  `QRS_ASSERT_IMPL(a_lanes_aligned, 1'b1, vp == vm)
  `QRS_ASSERT_NEXT(a_zero_roots, vp && zero_roots,
                   out_root_plus == '0 && out_root_minus == '0)
  `QRS_ASSERT_NEXT(a_double_equal, vp && st_d_r[qrs_pkg::QuoW] == qrs_pkg::ST_DOUBLE,
                   out_root_plus == out_root_minus)
endmodule
